// ===== design/jsch_pkg.sv =====
// Shared types, codes and field widths of the job scheduler.
package jsch_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF   = 16;

    localparam int ID_W       = 8;
    localparam int FTIME_W    = 16;
    localparam int QCOUNT_W   = 5;
    localparam int POLICY_W   = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 88;
    localparam int OUT_USER_W = 3;

    localparam logic [POLICY_W-1:0] POL_FCFS = 2'd0;
    localparam logic [POLICY_W-1:0] POL_SJF  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_HRRN = 2'd2;

    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_ARRIVAL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_DAT,
        ST_SCAN_CMP,
        ST_DISPATCH,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                arrival_dropped;
        logic                finished_valid;
        logic [ID_W-1:0]     finished_id;
        logic [FTIME_W-1:0]  finished_turnaround;
        logic                started_valid;
        logic [ID_W-1:0]     started_id;
        logic [FTIME_W-1:0]  started_time;
        logic [FTIME_W-1:0]  planned_end;
        logic [FTIME_W-1:0]  time_now;
        logic [QCOUNT_W-1:0] queue_count;
    } res_t;

endpackage

// ===== design/jsch_rank.sv =====
// Compare unit: ranks one queue candidate against the current best entry.
module jsch_rank #(
    parameter int TIME_BITS = jsch_pkg::TIME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          load,
    input  logic [jsch_pkg::POLICY_W-1:0] policy,
    input  logic [TIME_BITS-1:0]          now,
    input  logic [TIME_BITS-1:0]          cand_arr,
    input  logic [TIME_BITS-1:0]          cand_svc,
    input  logic [TIME_BITS-1:0]          best_wait,
    input  logic [TIME_BITS-1:0]          best_svc,
    output logic [TIME_BITS-1:0]          cand_wait,
    output logic                          better
);

    logic [2*TIME_BITS-1:0] prod_cand_reg;
    logic [2*TIME_BITS-1:0] prod_best_reg;
    logic                   less_reg;

    assign cand_wait = now - cand_arr;

    // Response ratios are compared by cross-multiplication, so no divider.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_cand_reg <= cand_wait * best_svc;
            prod_best_reg <= best_wait * cand_svc;
            less_reg      <= cand_svc < best_svc;
        end
    end

    always_comb
    begin
        case (policy)
            jsch_pkg::POL_SJF:  better = less_reg;
            jsch_pkg::POL_HRRN: better = prod_cand_reg > prod_best_reg;
            default:            better = 1'b0;
        endcase
    end

endmodule

// ===== design/jsch_ctrl.sv =====
// Sequencer with the ready-queue memory, the runner state and the time counter.
module jsch_ctrl #(
    parameter int QUEUE_DEPTH = jsch_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = jsch_pkg::TIME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [jsch_pkg::POLICY_W-1:0] policy,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_type,
    input  logic [jsch_pkg::ID_W-1:0]     in_id,
    input  logic [jsch_pkg::FTIME_W-1:0]  in_arr,
    input  logic [jsch_pkg::FTIME_W-1:0]  in_svc,
    output logic                          res_valid,
    input  logic                          res_take,
    output jsch_pkg::res_t                res
);

    localparam int TW = TIME_BITS;
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = jsch_pkg::ID_W + 2 * TW;

    jsch_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg;
    logic [TW-1:0] time_reg;
    logic          busy_reg;
    logic [jsch_pkg::ID_W-1:0] run_id_reg;
    logic [TW-1:0] run_end_reg;
    logic [TW-1:0] run_arr_reg;
    logic [AW-1:0] idx_reg;

    logic [TW-1:0] now_reg;
    logic [AW-1:0] best_idx_reg;
    logic [jsch_pkg::ID_W-1:0] best_id_reg;
    logic [TW-1:0] best_arr_reg;
    logic [TW-1:0] best_svc_reg;
    logic [TW-1:0] best_wait_reg;
    jsch_pkg::res_t res_reg;
    jsch_pkg::res_t res_next;

    logic [EW-1:0] queue_mem [QUEUE_DEPTH];
    logic [EW-1:0] rdata_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    logic [jsch_pkg::ID_W-1:0] cand_id;
    logic [TW-1:0] cand_arr;
    logic [TW-1:0] cand_svc;
    logic [TW-1:0] cand_wait;
    logic          better;

    logic          accept;
    logic          is_arrival;
    logic          room;
    logic          fin_hit;
    logic          busy_left;
    logic          want_pick;
    logic          ranked;
    logic [CW-1:0] scan_last;
    logic          scan_end;
    logic          take_cand;
    logic          shift_first;
    logic          shift_more;

    assign cand_id  = rdata_reg[jsch_pkg::ID_W-1:0];
    assign cand_arr = rdata_reg[jsch_pkg::ID_W +: TW];
    assign cand_svc = rdata_reg[jsch_pkg::ID_W + TW +: TW];

    assign accept      = in_ready && in_valid;
    assign is_arrival  = (in_type == jsch_pkg::REQ_ARRIVAL);
    assign room        = count_reg < CW'(QUEUE_DEPTH);
    assign fin_hit     = busy_reg && (run_end_reg == time_reg);
    assign busy_left   = busy_reg && !fin_hit;
    assign want_pick   = !busy_left && (count_reg != '0);
    assign ranked      = (policy == jsch_pkg::POL_SJF) || (policy == jsch_pkg::POL_HRRN);
    assign scan_last   = ranked ? (count_reg - CW'(1)) : '0;
    assign scan_end    = (CW'(idx_reg) == scan_last);
    assign take_cand   = (idx_reg == '0) || better;
    assign shift_first = (CW'(best_idx_reg) + CW'(1)) < count_reg;
    // The count has already dropped by one while the shift runs.
    assign shift_more  = (CW'(idx_reg) + CW'(1)) < count_reg;

    jsch_rank #(
        .TIME_BITS(TIME_BITS)
    ) u_rank (
        .clk      (clk),
        .load     (state_reg == jsch_pkg::ST_SCAN_DAT),
        .policy   (policy),
        .now      (now_reg),
        .cand_arr (cand_arr),
        .cand_svc (cand_svc),
        .best_wait(best_wait_reg),
        .best_svc (best_svc_reg),
        .cand_wait(cand_wait),
        .better   (better)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            jsch_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!is_arrival && want_pick)
                        state_next = jsch_pkg::ST_SCAN_RD;
                    else
                        state_next = jsch_pkg::ST_DONE;
                end
            end
            jsch_pkg::ST_SCAN_RD:  state_next = jsch_pkg::ST_SCAN_DAT;
            jsch_pkg::ST_SCAN_DAT: state_next = jsch_pkg::ST_SCAN_CMP;
            jsch_pkg::ST_SCAN_CMP:
                state_next = scan_end ? jsch_pkg::ST_DISPATCH : jsch_pkg::ST_SCAN_RD;
            jsch_pkg::ST_DISPATCH:
                state_next = shift_first ? jsch_pkg::ST_SHIFT_RD : jsch_pkg::ST_DONE;
            jsch_pkg::ST_SHIFT_RD: state_next = jsch_pkg::ST_SHIFT_WR;
            jsch_pkg::ST_SHIFT_WR:
                state_next = shift_more ? jsch_pkg::ST_SHIFT_RD : jsch_pkg::ST_DONE;
            jsch_pkg::ST_DONE:
            begin
                if (res_take)
                    state_next = jsch_pkg::ST_IDLE;
            end
            default: state_next = jsch_pkg::ST_IDLE;
        endcase
    end

    // The shift reads one entry ahead of the write, and an arrival is written
    // only while idle, so a read never meets a pending write to its entry.
    always_comb
    begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = idx_reg;
        wr_en     = 1'b0;
        wr_addr   = idx_reg;
        wr_data   = rdata_reg;
        unique case (state_reg)
            jsch_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                wr_en    = in_valid && is_arrival && room;
                wr_addr  = count_reg[AW-1:0];
                wr_data  = {TW'(in_svc), TW'(in_arr), in_id};
            end
            jsch_pkg::ST_SCAN_RD:
                rd_en = 1'b1;
            jsch_pkg::ST_SHIFT_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg + AW'(1);
            end
            jsch_pkg::ST_SHIFT_WR:
                wr_en = 1'b1;
            jsch_pkg::ST_DONE:
                res_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            queue_mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= queue_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= jsch_pkg::ST_IDLE;
            count_reg   <= '0;
            time_reg    <= '0;
            busy_reg    <= 1'b0;
            run_id_reg  <= '0;
            run_end_reg <= '0;
            run_arr_reg <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                if (is_arrival)
                begin
                    if (room)
                        count_reg <= count_reg + CW'(1);
                end
                else
                begin
                    time_reg <= time_reg + TW'(1);
                    busy_reg <= busy_left;
                    idx_reg  <= '0;
                end
            end
            if (state_reg == jsch_pkg::ST_SCAN_CMP && !scan_end)
                idx_reg <= idx_reg + AW'(1);
            if (state_reg == jsch_pkg::ST_DISPATCH)
            begin
                busy_reg    <= 1'b1;
                run_id_reg  <= best_id_reg;
                run_arr_reg <= best_arr_reg;
                run_end_reg <= now_reg + best_svc_reg;
                count_reg   <= count_reg - CW'(1);
                idx_reg     <= best_idx_reg;
            end
            if (state_reg == jsch_pkg::ST_SHIFT_WR)
                idx_reg <= idx_reg + AW'(1);
        end
    end

    always_comb
    begin
        res_next = res_reg;
        if (accept)
        begin
            res_next                 = '0;
            res_next.arrival_dropped = is_arrival && !room;
            res_next.time_now        = jsch_pkg::FTIME_W'(time_reg);
            if (!is_arrival && fin_hit)
            begin
                res_next.finished_valid      = 1'b1;
                res_next.finished_id         = run_id_reg;
                res_next.finished_turnaround =
                    jsch_pkg::FTIME_W'(run_end_reg - run_arr_reg);
            end
        end
        if (state_reg == jsch_pkg::ST_DISPATCH)
        begin
            res_next.started_valid = 1'b1;
            res_next.started_id    = best_id_reg;
            res_next.started_time  = jsch_pkg::FTIME_W'(now_reg);
            res_next.planned_end   = jsch_pkg::FTIME_W'(now_reg + best_svc_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            now_reg <= time_reg;
        res_reg <= res_next;
        if (state_reg == jsch_pkg::ST_SCAN_CMP && take_cand)
        begin
            best_idx_reg  <= idx_reg;
            best_id_reg   <= cand_id;
            best_arr_reg  <= cand_arr;
            best_svc_reg  <= cand_svc;
            best_wait_reg <= cand_wait;
        end
    end

    always_comb
    begin
        res             = res_reg;
        res.queue_count = jsch_pkg::QCOUNT_W'(count_reg);
    end

endmodule

// ===== design/nonpreemptive_job_scheduler_top.sv =====
// Top level of the non-preemptive job scheduler: policy register, ports and result beat register.
//
// One input beat is handled at a time. An arrival beat, or a tick that dispatches nothing,
// goes straight from acceptance to its result beat. A tick that dispatches reads the ready
// queue memory one entry at a time through read, data and compare states into the single
// compare unit (every waiting entry under shortest job first and highest response ratio next,
// only the head entry under first come first served or any other policy code), passes the
// dispatch state, then closes the gap in the queue by moving each entry behind the picked one
// forward with a read and a write state. The result waits in its own register, so the next
// beat is accepted while the previous result is still held. The user must write the policy
// register over cfg_valid/cfg_ready only while the block is idle; the block does not enforce it.
module nonpreemptive_job_scheduler_top #(
    parameter int QUEUE_DEPTH = jsch_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = jsch_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [jsch_pkg::POLICY_W-1:0]   cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // job id, arrival time, service time
    input  logic [jsch_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // finished_id, finished_turnaround, started_id, started_time, planned_end,
    // time_now, queue_count, zero fill
    output logic [jsch_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // arrival_dropped, finished_valid, started_valid
    output logic [jsch_pkg::OUT_USER_W-1:0] m_axis_tuser
);

    logic [jsch_pkg::POLICY_W-1:0] policy_reg;
    logic                          out_valid_reg;
    jsch_pkg::res_t                out_reg;
    jsch_pkg::res_t                res;
    logic                          res_valid;
    logic                          res_take;

    assign cfg_ready = 1'b1;
    assign res_take  = !out_valid_reg || m_axis_tready;

    jsch_ctrl #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TIME_BITS  (TIME_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .policy   (policy_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_type  (s_axis_tuser),
        .in_id    (s_axis_tdata[7:0]),
        .in_arr   (s_axis_tdata[23:8]),
        .in_svc   (s_axis_tdata[39:24]),
        .res_valid(res_valid),
        .res_take (res_take),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= jsch_pkg::POL_FCFS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                policy_reg <= cfg_data;
            if (res_valid && res_take)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg.queue_count, out_reg.time_now,
                            out_reg.planned_end, out_reg.started_time, out_reg.started_id,
                            out_reg.finished_turnaround, out_reg.finished_id};
    assign m_axis_tuser  = {out_reg.started_valid, out_reg.finished_valid,
                            out_reg.arrival_dropped};

endmodule

// ===== design/jsch_checker.sv =====
// Port-level checks of the job scheduler and their binding to the top level.
module jsch_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [jsch_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [jsch_pkg::OUT_USER_W-1:0] m_axis_tuser
);

    // A held result beat keeps its contents until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // Only an arrival can be dropped, and a dropped arrival never finishes or starts a job.
    a_drop_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1] && !m_axis_tuser[2])
        else $error("dropped arrival also reports finish or start");

    // A dispatched job starts at the time of the tick that dispatched it.
    a_start_now: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tdata[47:32] == m_axis_tdata[79:64])
        else $error("start time differs from current time");

    // Items are handled one at a time: an accepted beat blocks the next cycle.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

endmodule

bind nonpreemptive_job_scheduler_top jsch_checker u_jsch_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);

// ===== dv/tb_nonpreemptive_job_scheduler_top.sv =====
// Testbench for the non-preemptive job scheduler: directed and random traffic with a scoreboard.
`timescale 1ns / 1ps

module tb_nonpreemptive_job_scheduler_top;

    import jsch_pkg::*;

    localparam int QDEPTH = QUEUE_DEPTH_DEF;
    localparam logic [POLICY_W-1:0] POL_UNDEFINED = 2'd3;
    // The settle time is sized for the worst dispatch, with a full queue under a ranked policy.
    localparam int SETTLE_CYCLES = 120;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [POLICY_W-1:0]   cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    // Idle percentages for the sender and the receiver.
    int src_idle = 0;
    int sink_stall = 0;
    int fault_count = 0;

    // Scheduler state as the testbench tracks it.
    logic [POLICY_W-1:0] sched_policy = POL_FCFS;
    logic [ID_W-1:0]     q_id[QDEPTH];
    logic [FTIME_W-1:0]  q_arr[QDEPTH];
    logic [FTIME_W-1:0]  q_svc[QDEPTH];
    int                  q_count = 0;
    logic [FTIME_W-1:0]  cur_time = '0;
    logic                running = 1'b0;
    logic [ID_W-1:0]     run_id = '0;
    logic [FTIME_W-1:0]  run_end = '0;
    logic [FTIME_W-1:0]  run_arr = '0;

    res_t outcome_q[$];

    nonpreemptive_job_scheduler_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall);
    end

    // Apply one item to the tracked state and work out the beat it should produce.
    task automatic advance_scheduler(input logic kind, input logic [ID_W-1:0] id,
                                     input logic [FTIME_W-1:0] arr,
                                     input logic [FTIME_W-1:0] svc, output res_t r);
        int best;
        logic [FTIME_W-1:0] wk;
        logic [FTIME_W-1:0] wb;
        logic [31:0] lhs;
        logic [31:0] rhs;
        r = '0;
        r.time_now = cur_time;
        if (kind == REQ_ARRIVAL)
        begin
            if (q_count < QDEPTH)
            begin
                q_id[q_count] = id;
                q_arr[q_count] = arr;
                q_svc[q_count] = svc;
                q_count++;
            end
            else
            begin
                r.arrival_dropped = 1'b1;
            end
        end
        else
        begin
            if (running && run_end == cur_time)
            begin
                r.finished_valid = 1'b1;
                r.finished_id = run_id;
                r.finished_turnaround = run_end - run_arr;
                running = 1'b0;
            end
            if (!running && q_count > 0)
            begin
                best = 0;
                if (sched_policy == POL_SJF)
                begin
                    for (int k = 1; k < q_count; k++)
                        if (q_svc[k] < q_svc[best])
                            best = k;
                end
                else if (sched_policy == POL_HRRN)
                begin
                    // Ratios are ranked by cross-multiplying wait and service.
                    for (int k = 1; k < q_count; k++)
                    begin
                        wk = cur_time - q_arr[k];
                        wb = cur_time - q_arr[best];
                        lhs = wk * q_svc[best];
                        rhs = wb * q_svc[k];
                        if (lhs > rhs)
                            best = k;
                    end
                end
                run_id = q_id[best];
                run_arr = q_arr[best];
                run_end = cur_time + q_svc[best];
                running = 1'b1;
                r.started_valid = 1'b1;
                r.started_id = run_id;
                r.started_time = cur_time;
                r.planned_end = run_end;
                for (int k = best; k + 1 < q_count; k++)
                begin
                    q_id[k] = q_id[k + 1];
                    q_arr[k] = q_arr[k + 1];
                    q_svc[k] = q_svc[k + 1];
                end
                q_count--;
            end
            cur_time = cur_time + 1'b1;
        end
        r.queue_count = q_count[QCOUNT_W-1:0];
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            fault_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (outcome_q.size() == 0)
            begin
                fault_count++;
                $display("%0t: result beat expected none actual tuser %h tdata %h",
                         $time, m_axis_tuser, m_axis_tdata);
            end
            else
            begin
                want = outcome_q.pop_front();
                check_field("arrival_dropped", want.arrival_dropped, m_axis_tuser[0]);
                check_field("finished_valid", want.finished_valid, m_axis_tuser[1]);
                check_field("started_valid", want.started_valid, m_axis_tuser[2]);
                check_field("finished_id", want.finished_id, m_axis_tdata[7:0]);
                check_field("finished_turnaround", want.finished_turnaround,
                            m_axis_tdata[23:8]);
                check_field("started_id", want.started_id, m_axis_tdata[31:24]);
                check_field("started_time", want.started_time, m_axis_tdata[47:32]);
                check_field("planned_end", want.planned_end, m_axis_tdata[63:48]);
                check_field("time_now", want.time_now, m_axis_tdata[79:64]);
                check_field("queue_count", want.queue_count, m_axis_tdata[84:80]);
                check_field("zero fill", 0, m_axis_tdata[87:85]);
            end
        end
    end

    task automatic send_job(input logic kind, input logic [ID_W-1:0] id,
                            input logic [FTIME_W-1:0] arr, input logic [FTIME_W-1:0] svc);
        res_t r;
        while ($urandom_range(0, 99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {svc, arr, id};
        do
            @(posedge clk);
        while (!s_axis_tready);
        advance_scheduler(kind, id, arr, svc, r);
        outcome_q.insert(outcome_q.size(), r);
    endtask

    task automatic tick();
        send_job(REQ_TICK, ID_W'($urandom), FTIME_W'($urandom), FTIME_W'($urandom));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_policy(input logic [POLICY_W-1:0] pol);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= pol;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sched_policy = pol;
    endtask

    // Empty ticks, a job that arrives in the future, extreme ids and arrival times.
    task automatic test_fcfs_basics();
        set_policy(POL_FCFS);
        tick();
        send_job(REQ_ARRIVAL, 8'hFF, 16'hFFFF, 16'd3);
        send_job(REQ_ARRIVAL, 8'h00, 16'h0000, 16'd1);
        repeat (5) tick();
    endtask

    // Sixteen queued jobs and one more that gets dropped, then a few ticks by length.
    task automatic test_queue_full();
        set_policy(POL_SJF);
        for (int k = 0; k <= QDEPTH; k++)
            send_job(REQ_ARRIVAL, ID_W'(8'h10 + k), cur_time, FTIME_W'($urandom_range(1, 4)));
        repeat (3) tick();
    endtask

    task automatic test_random_traffic(input logic [POLICY_W-1:0] pol, input int src_pct,
                                       input int sink_pct, input int n);
        int arrive_pct;
        logic [FTIME_W-1:0] arr;
        logic [FTIME_W-1:0] svc;
        set_policy(pol);
        src_idle = src_pct;
        sink_stall = sink_pct;
        for (int i = 0; i < n; i++)
        begin
            arrive_pct = (q_count >= 14) ? 15 : (q_count < 3) ? 60 : 40;
            if ($urandom_range(0, 99) < arrive_pct)
            begin
                // Mostly recent arrivals with short jobs; now and then any arrival time.
                if ($urandom_range(0, 3) == 0)
                    arr = FTIME_W'($urandom);
                else
                    arr = cur_time - FTIME_W'($urandom_range(0, 30));
                if ($urandom_range(0, 4) == 0)
                    svc = FTIME_W'($urandom_range(7, 40));
                else
                    svc = FTIME_W'($urandom_range(1, 6));
                send_job(REQ_ARRIVAL, ID_W'($urandom), arr, svc);
            end
            else
            begin
                tick();
            end
        end
    endtask

    // Zero and maximum service times park the runner for the rest of the run, so they go last.
    task automatic test_long_jobs();
        set_policy(POL_HRRN);
        src_idle = 10;
        sink_stall = 10;
        send_job(REQ_ARRIVAL, 8'hAA, cur_time, 16'hFFFF);
        send_job(REQ_ARRIVAL, 8'h55, cur_time - 16'd2, 16'd0);
        send_job(REQ_ARRIVAL, 8'h5A, FTIME_W'($urandom), FTIME_W'($urandom));
        repeat (40) tick();
        send_job(REQ_ARRIVAL, 8'hA5, FTIME_W'($urandom), FTIME_W'($urandom));
        repeat (4) tick();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fcfs_basics();
        test_queue_full();
        test_random_traffic(POL_FCFS, 0, 0, 150);
        test_random_traffic(POL_SJF, 49, 0, 150);
        test_random_traffic(POL_HRRN, 0, 49, 150);
        test_random_traffic(POL_UNDEFINED, 10, 10, 150);
        test_random_traffic(POL_HRRN, 0, 0, 150);
        test_random_traffic(POL_SJF, 49, 0, 150);
        test_random_traffic(POL_FCFS, 0, 49, 150);
        test_random_traffic(POL_HRRN, 10, 10, 150);
        test_long_jobs();
        wait_drained();
        if (fault_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
